// ===== rtl/pipr_pkg.sv =====
// Shared types and constants for the ray-cast point-in-polygon block.
package pipr_pkg;

    // Coordinate and vertex formats (signed Q11.4, x in the upper half)
    localparam int COORD_W = 16;
    localparam int VTX_W   = 2 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // Smallest vertex count that encloses any area
    localparam int MIN_POLY_VERTICES = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [VTX_W-1:0]          t_vertex;

    // Request codes
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // Configuration register indexes
    localparam logic CFG_COLLINEAR_EPSILON = 1'b0;
    localparam logic CFG_RAY_END_X         = 1'b1;

    // Configuration reset values
    localparam logic [COORD_W-1:0] EPS_RESET   = 16'd1;
    localparam logic [COORD_W-1:0] RAY_X_RESET = 16'h7FFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Orientation of a point against a directed line
    typedef enum logic [1:0] {
        ORI_ZERO,
        ORI_POS,
        ORI_NEG
    } t_orient;

    // Control of one vertex cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Edge issued into the test pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_edge_ctl;

    // Outcome of one edge test
    typedef struct packed {
        logic valid;
        logic last;
        logic meets;
        logic on_edge;
        logic box_p;
    } t_edge_res;

endpackage

// ===== rtl/pipr_cell.sv =====
// One vertex cell of the rotating vertex chain.
module pipr_cell (
    input  logic               i_clk,
    input  pipr_pkg::t_cell_ctl i_ctl,
    input  pipr_pkg::t_vertex  i_wdata,
    input  pipr_pkg::t_vertex  i_next,
    output pipr_pkg::t_vertex  o_vtx
);
    import pipr_pkg::*;

    t_vertex r_vtx;

    // Load an appended vertex, or take the neighbor's vertex while rotating
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_vtx <= i_wdata;
        end else if (i_ctl.shift) begin
            r_vtx <= i_next;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ===== rtl/pipr_edge_test.sv =====
// Four-stage pipeline that tests one polygon edge against the ray per cycle.
module pipr_edge_test (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pipr_pkg::t_edge_ctl i_ctl,
    input  pipr_pkg::t_coord    i_ax,
    input  pipr_pkg::t_coord    i_ay,
    input  pipr_pkg::t_coord    i_bx,
    input  pipr_pkg::t_coord    i_by,
    input  pipr_pkg::t_coord    i_px,
    input  pipr_pkg::t_coord    i_py,
    input  pipr_pkg::t_coord    i_ex,
    input  logic [pipr_pkg::COORD_W-1:0] i_eps,
    output pipr_pkg::t_edge_res o_res
);
    import pipr_pkg::*;

    // Inclusive bounding-box test of q against segment s-t
    function automatic logic in_box(input t_coord sx, input t_coord sy,
                                    input t_coord tx, input t_coord ty,
                                    input t_coord qx, input t_coord qy);
        t_coord xlo;
        t_coord xhi;
        t_coord ylo;
        t_coord yhi;
        xlo = (sx < tx) ? sx : tx;
        xhi = (sx < tx) ? tx : sx;
        ylo = (sy < ty) ? sy : ty;
        yhi = (sy < ty) ? ty : sy;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    // Classify a cross product against the collinear threshold
    function automatic t_orient orient_of(input logic signed [CROSS_W-1:0] c,
                                          input logic [COORD_W-1:0] eps);
        logic [CROSS_W-1:0] mag;
        t_orient            o;
        mag = c[CROSS_W-1] ? CROSS_W'(-c) : CROSS_W'(c);
        if (mag < CROSS_W'(eps)) begin
            o = ORI_ZERO;
        end else if (!c[CROSS_W-1] && (c != '0)) begin
            o = ORI_POS;
        end else begin
            o = ORI_NEG;
        end
        return o;
    endfunction

    // Stage 1: differences and bounding boxes
    t_edge_ctl                r_s1_ctl;
    logic [3:0]               r_s1_box;
    logic signed [DIFF_W-1:0] r_s1_pxa;
    logic signed [DIFF_W-1:0] r_s1_exa;
    logic signed [DIFF_W-1:0] r_s1_dby;
    logic signed [DIFF_W-1:0] r_s1_dbx;
    logic signed [DIFF_W-1:0] r_s1_pya;
    logic signed [DIFF_W-1:0] r_s1_epx;
    logic signed [DIFF_W-1:0] r_s1_ayp;
    logic signed [DIFF_W-1:0] r_s1_byp;

    // Stage 2: products
    t_edge_ctl                r_s2_ctl;
    logic [3:0]               r_s2_box;
    logic signed [PROD_W-1:0] r_s2_m1;
    logic signed [PROD_W-1:0] r_s2_m2;
    logic signed [PROD_W-1:0] r_s2_m3;
    logic signed [PROD_W-1:0] r_s2_m5;
    logic signed [PROD_W-1:0] r_s2_m6;

    // Stage 3: cross products
    t_edge_ctl                 r_s3_ctl;
    logic [3:0]                r_s3_box;
    logic signed [CROSS_W-1:0] r_s3_c [4];

    // Stage 4: orientations
    t_edge_ctl r_s4_ctl;
    logic [3:0] r_s4_box;
    t_orient    r_s4_o [4];

    logic w_meets;

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
    end

    // Advance the data path
    always_ff @(posedge i_clk) begin
        r_s1_box[0] <= in_box(i_ax, i_ay, i_bx, i_by, i_px, i_py);
        r_s1_box[1] <= in_box(i_ax, i_ay, i_bx, i_by, i_ex, i_py);
        r_s1_box[2] <= in_box(i_px, i_py, i_ex, i_py, i_ax, i_ay);
        r_s1_box[3] <= in_box(i_px, i_py, i_ex, i_py, i_bx, i_by);
        r_s1_pxa    <= DIFF_W'(i_px) - DIFF_W'(i_ax);
        r_s1_exa    <= DIFF_W'(i_ex) - DIFF_W'(i_ax);
        r_s1_dby    <= DIFF_W'(i_by) - DIFF_W'(i_ay);
        r_s1_dbx    <= DIFF_W'(i_bx) - DIFF_W'(i_ax);
        r_s1_pya    <= DIFF_W'(i_py) - DIFF_W'(i_ay);
        r_s1_epx    <= DIFF_W'(i_ex) - DIFF_W'(i_px);
        r_s1_ayp    <= DIFF_W'(i_ay) - DIFF_W'(i_py);
        r_s1_byp    <= DIFF_W'(i_by) - DIFF_W'(i_py);

        r_s2_box <= r_s1_box;
        r_s2_m1  <= r_s1_pxa * r_s1_dby;
        r_s2_m2  <= r_s1_dbx * r_s1_pya;
        r_s2_m3  <= r_s1_exa * r_s1_dby;
        r_s2_m5  <= r_s1_epx * r_s1_ayp;
        r_s2_m6  <= r_s1_epx * r_s1_byp;

        // The ray is horizontal, so orient(P,E,A) and orient(P,E,B) keep one term
        r_s3_box  <= r_s2_box;
        r_s3_c[0] <= CROSS_W'(r_s2_m1) - CROSS_W'(r_s2_m2);
        r_s3_c[1] <= CROSS_W'(r_s2_m3) - CROSS_W'(r_s2_m2);
        r_s3_c[2] <= -CROSS_W'(r_s2_m5);
        r_s3_c[3] <= -CROSS_W'(r_s2_m6);

        r_s4_box <= r_s3_box;
        for (int k = 0; k < 4; k++) begin
            r_s4_o[k] <= orient_of(r_s3_c[k], i_eps);
        end
    end

    // Combine orientations into the segment intersection verdict
    always_comb begin
        w_meets = ((r_s4_o[0] == ORI_ZERO) && r_s4_box[0])
               || ((r_s4_o[1] == ORI_ZERO) && r_s4_box[1])
               || ((r_s4_o[2] == ORI_ZERO) && r_s4_box[2])
               || ((r_s4_o[3] == ORI_ZERO) && r_s4_box[3])
               || ((r_s4_o[0] != r_s4_o[1]) && (r_s4_o[2] != r_s4_o[3]));
    end

    assign o_res.valid   = r_s4_ctl.valid;
    assign o_res.last    = r_s4_ctl.last;
    assign o_res.meets   = w_meets;
    assign o_res.on_edge = w_meets && (r_s4_o[0] == ORI_ZERO);
    assign o_res.box_p   = r_s4_box[0];

endmodule

// ===== rtl/point_in_polygon_ray_cast.sv =====
// Top level of the ray-cast point-in-polygon block.
//
// Input channel (i_in_valid / o_in_stall) carries one request per transaction:
// req_type 0 appends vertex (coord_x, coord_y), req_type 1 queries that point.
// Output channel (o_out_valid / i_out_stall) returns one result per request:
// inside_res for queries, status 1 when an append found the store full.
// An append, or a query with fewer than three vertices, shows its result in
// the cycle after acceptance. A query on n >= 3 vertices tests its n edges:
// the vertex chain rotates one cell per cycle and the single edge-test
// pipeline (four register stages) checks one edge per cycle. No new request
// is taken before that result is loaded.
// Configuration writes (i_cfg_we) take effect at once and are expected only
// while the block is idle.
// Reset clears the vertex count, sets collinear_epsilon to 1 and ray_end_x to
// 32767; vertex cells are not cleared and are only read once written.
// While the receiver stalls, the result holds in the output register; a new
// request is taken only when that register is empty or being emptied.
module point_in_polygon_ray_cast #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  pipr_pkg::t_coord              i_coord_x,
    input  pipr_pkg::t_coord              i_coord_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [pipr_pkg::COORD_W-1:0]  i_cfg_data
);
    import pipr_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Configuration registers
    logic [COORD_W-1:0] r_eps;
    t_coord             r_ray_x;

    // Control state
    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_step;
    logic [CW-1:0] n_step;
    logic          r_found;
    logic          n_found;
    logic          r_res;
    logic          n_res;
    logic          r_par;
    logic          n_par;

    // Query point
    t_coord r_px;
    t_coord r_py;

    // Output register
    logic r_out_valid;
    logic n_out_valid;
    logic r_inside;
    logic n_inside;
    logic r_status;
    logic n_status;

    logic          w_in_acc;
    logic          w_full;
    logic          w_add_ok;
    logic          w_issue;
    logic          w_out_load;
    logic [CW-1:0] w_last_idx;
    t_edge_ctl     w_edge_ctl;
    t_edge_res     w_edge_res;
    t_vertex       w_vtx [MAX_VERTICES];

    assign o_in_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(MAX_VERTICES));
    assign w_add_ok   = w_in_acc && (i_req_type == REQ_ADD) && !w_full;
    assign w_last_idx = r_count - CW'(1);

    // Vertex chain: cell i holds vertex i, rotation wraps at the vertex count
    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_vertex   w_next;

        assign w_ctl.load  = w_add_ok && (r_count == CW'(i));
        assign w_ctl.shift = w_issue;

        if (i == MAX_VERTICES - 1) begin : g_tail
            assign w_next = w_vtx[0];
        end else begin : g_body
            assign w_next = (w_last_idx == CW'(i)) ? w_vtx[0] : w_vtx[i+1];
        end

        pipr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_wdata ({i_coord_x, i_coord_y}),
            .i_next  (w_next),
            .o_vtx   (w_vtx[i])
        );
    end

    // Edge under test: the two head cells of the rotating chain
    assign w_edge_ctl.valid = w_issue;
    assign w_edge_ctl.last  = (r_step == w_last_idx);

    pipr_edge_test u_edge_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_edge_ctl),
        .i_ax    (t_coord'(w_vtx[0][VTX_W-1:COORD_W])),
        .i_ay    (t_coord'(w_vtx[0][COORD_W-1:0])),
        .i_bx    (t_coord'(w_vtx[1][VTX_W-1:COORD_W])),
        .i_by    (t_coord'(w_vtx[1][COORD_W-1:0])),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ex    (r_ray_x),
        .i_eps   (r_eps),
        .o_res   (w_edge_res)
    );

    // Accumulate crossings; the first collinear hit settles the answer
    always_comb begin
        n_found = r_found;
        n_res   = r_res;
        n_par   = r_par;
        if (w_in_acc) begin
            n_found = 1'b0;
            n_res   = 1'b0;
            n_par   = 1'b0;
        end else if (w_edge_res.valid && !r_found) begin
            if (w_edge_res.on_edge) begin
                n_found = 1'b1;
                n_res   = w_edge_res.box_p;
            end else if (w_edge_res.meets) begin
                n_par = !r_par;
            end
        end
    end

    // Sequence requests: append, short query, edge sweep, pipeline drain
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_count    = r_count;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        n_inside   = 1'b0;
        n_status   = STAT_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_req_type == REQ_ADD) begin
                        w_out_load = 1'b1;
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count < CW'(MIN_POLY_VERTICES)) begin
                        w_out_load = 1'b1;
                    end else begin
                        n_step  = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                w_issue = 1'b1;
                n_step  = r_step + CW'(1);
                if (r_step == w_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_edge_res.valid && w_edge_res.last) begin
                    w_out_load = 1'b1;
                    n_inside   = n_found ? n_res : n_par;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold or drop the output transaction
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_res       <= 1'b0;
            r_par       <= 1'b0;
            r_out_valid <= 1'b0;
            r_eps       <= EPS_RESET;
            r_ray_x     <= t_coord'(RAY_X_RESET);
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_found     <= n_found;
            r_res       <= n_res;
            r_par       <= n_par;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLLINEAR_EPSILON: r_eps   <= i_cfg_data;
                    CFG_RAY_END_X:         r_ray_x <= t_coord'(i_cfg_data);
                    default:               r_eps   <= r_eps;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (w_out_load) begin
            r_inside <= n_inside;
            r_status <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_status     = r_status;

endmodule

// ===== verif/point_in_polygon_ray_cast_check.sv =====
// Scoreboard for the ray-cast point-in-polygon block: predicts every reply and compares it.
`timescale 1ns / 1ps
module point_in_polygon_ray_cast_check #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  pipr_pkg::t_coord              i_coord_x,
    input  pipr_pkg::t_coord              i_coord_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_inside_res,
    input  logic                          i_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [pipr_pkg::COORD_W-1:0]  i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count,
    output int                            o_inside_count
);
    import pipr_pkg::*;

    // One predicted reply, with the request that caused it
    typedef struct packed {
        logic   is_query;
        t_coord req_x;
        t_coord req_y;
        logic   inside_res;
        logic   status;
    } t_reply;

    t_reply             predicted_replies[$];
    t_coord             poly_x[MAX_VERTICES];
    t_coord             poly_y[MAX_VERTICES];
    int unsigned        poly_count;
    logic [COORD_W-1:0] epsilon;
    t_coord             ray_x;
    int                 fail_total = 0;
    int                 inside_total = 0;
    int                 reply_seen = 0;

    assign o_fail_count   = fail_total;
    assign o_inside_count = inside_total;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Exact 2D cross product of (Q - S) and (T - S)
    function automatic longint cross_of(input longint sx, sy, tx, ty, qx, qy);
        return (qx - sx) * (ty - sy) - (tx - sx) * (qy - sy);
    endfunction

    function automatic logic is_collinear(input longint c);
        longint mag;
        mag = (c < 0) ? -c : c;
        return mag < longint'(epsilon);
    endfunction

    function automatic t_orient orient_of(input longint sx, sy, tx, ty, qx, qy);
        longint c;
        c = cross_of(sx, sy, tx, ty, qx, qy);
        if (is_collinear(c)) begin
            return ORI_ZERO;
        end else if (c > 0) begin
            return ORI_POS;
        end else begin
            return ORI_NEG;
        end
    endfunction

    // Inclusive bounding box of segment S-T contains Q
    function automatic logic within_box(input longint sx, sy, tx, ty, qx, qy);
        longint xlo, xhi, ylo, yhi;
        xlo = (sx < tx) ? sx : tx;
        xhi = (sx < tx) ? tx : sx;
        ylo = (sy < ty) ? sy : ty;
        yhi = (sy < ty) ? ty : sy;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    // Segment A-B against ray segment P-E
    function automatic logic ray_meets_edge(input longint ax, ay, bx, by, px, py, ex, ey);
        t_orient o1, o2, o3, o4;
        o1 = orient_of(ax, ay, bx, by, px, py);
        o2 = orient_of(ax, ay, bx, by, ex, ey);
        o3 = orient_of(px, py, ex, ey, ax, ay);
        o4 = orient_of(px, py, ex, ey, bx, by);
        if (o1 == ORI_ZERO && within_box(ax, ay, bx, by, px, py)) return 1'b1;
        if (o2 == ORI_ZERO && within_box(ax, ay, bx, by, ex, ey)) return 1'b1;
        if (o3 == ORI_ZERO && within_box(px, py, ex, ey, ax, ay)) return 1'b1;
        if (o4 == ORI_ZERO && within_box(px, py, ex, ey, bx, by)) return 1'b1;
        return (o1 != o2) && (o3 != o4);
    endfunction

    // Walk every closing edge; a collinear hit decides at once, else crossing parity
    function automatic logic predict_inside(input longint px, py);
        int unsigned nxt;
        longint      ax, ay, bx, by;
        int          hits;
        hits = 0;
        if (poly_count < MIN_POLY_VERTICES) return 1'b0;
        for (int unsigned i = 0; i < poly_count; i++) begin
            nxt = (i + 1 == poly_count) ? 0 : i + 1;
            ax  = poly_x[i];
            ay  = poly_y[i];
            bx  = poly_x[nxt];
            by  = poly_y[nxt];
            if (ray_meets_edge(ax, ay, bx, by, px, py, longint'(ray_x), py)) begin
                if (is_collinear(cross_of(ax, ay, bx, by, px, py))) begin
                    return within_box(ax, ay, bx, by, px, py);
                end
                hits++;
            end
        end
        return hits[0];
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_reply want;
        if (!i_rst_n) begin
            predicted_replies.delete();
            poly_count = 0;
            epsilon    = EPS_RESET;
            ray_x      = RAY_X_RESET;
        end else begin
            // Predict the reply of each accepted request
            if (i_in_valid && !i_in_stall) begin
                want          = '0;
                want.is_query = (i_req_type == REQ_QUERY);
                want.req_x    = i_coord_x;
                want.req_y    = i_coord_y;
                want.status   = STAT_OK;
                if (i_req_type == REQ_ADD) begin
                    if (poly_count >= MAX_VERTICES) begin
                        want.status = STAT_FULL;
                    end else begin
                        poly_x[poly_count] = i_coord_x;
                        poly_y[poly_count] = i_coord_y;
                        poly_count++;
                    end
                end else begin
                    want.inside_res = predict_inside(i_coord_x, i_coord_y);
                end
                predicted_replies = {predicted_replies, want};
            end

            // Compare each accepted reply with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                              reply_seen));
                end else begin
                    want = predicted_replies.pop_front();
                    if (i_inside_res !== want.inside_res) begin
                        report_mismatch($sformatf(
                            "reply %0d (%s x=%0d y=%0d): inside_res %b, predicted %b",
                            reply_seen, want.is_query ? "query" : "add",
                            want.req_x, want.req_y, i_inside_res, want.inside_res));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf(
                            "reply %0d (%s x=%0d y=%0d): status %b, predicted %b",
                            reply_seen, want.is_query ? "query" : "add",
                            want.req_x, want.req_y, i_status, want.status));
                    end
                    if (want.is_query && want.inside_res) begin
                        inside_total++;
                    end
                end
                reply_seen++;
            end

            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLLINEAR_EPSILON: epsilon = i_cfg_data;
                    CFG_RAY_END_X:         ray_x   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= predicted_replies.size();
    end

endmodule

// ===== verif/point_in_polygon_ray_cast_test.sv =====
// Stimulus, watchdog and verdict for the ray-cast point-in-polygon block.
`timescale 1ns / 1ps
module point_in_polygon_ray_cast_test;
    import pipr_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = MAX_VERTICES + 16;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 136;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               req_type  = REQ_ADD;
    t_coord             coord_x   = '0;
    t_coord             coord_y   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               inside_res;
    logic               status;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = CFG_COLLINEAR_EPSILON;
    logic [COORD_W-1:0] cfg_data  = '0;

    int   pending;
    int   fail_count;
    int   inside_count;
    int   stuck_cycles = 0;
    logic quiet        = 1'b0;
    int   stored_x[$];
    int   stored_y[$];
    int   add_total    = 0;
    int   full_total   = 0;
    int   query_total  = 0;
    int   phase_total  = 0;

    point_in_polygon_ray_cast #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_inside_res (inside_res),
        .o_status     (status),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    point_in_polygon_ray_cast_check #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_inside_res   (inside_res),
        .i_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_inside_count (inside_count)
    );

    always #1 clk = ~clk;

    // End the run when neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[point_in_polygon_ray_cast] ERROR");
            $finish;
        end
    end

    // Stall the reply channel in random bursts; hold it open in the quiet phase
    initial begin : reply_stall
        int len;
        @(posedge clk);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                len = $urandom_range(1, 14);
                case ($urandom_range(0, 3))
                    0: out_stall <= 1'b1;
                    1: begin
                        out_stall <= 1'b0;
                        len = len * 4;
                    end
                    default: out_stall <= 1'b0;
                endcase
                repeat (len) @(posedge clk);
            end
        end
    end

    function automatic int grid_coord();
        return (int'($urandom_range(0, 80)) - 40) * 64;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // Drive one request and hold it until the transaction is accepted
    task automatic send_req(input logic rt, input int x, input int y);
        in_valid <= 1'b1;
        req_type <= rt;
        coord_x  <= x[COORD_W-1:0];
        coord_y  <= y[COORD_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (rt == REQ_QUERY) begin
            query_total++;
        end else begin
            add_total++;
            if (stored_x.size() < MAX_VERTICES) begin
                stored_x = {stored_x, x};
                stored_y = {stored_y, y};
            end else begin
                full_total++;
            end
        end
    endtask

    // Drop valid for a random burst now and then
    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every reply is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write both registers back to back
    task automatic set_ray_config(input int eps, input int ray_end);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLLINEAR_EPSILON;
        cfg_data  <= eps[COORD_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_RAY_END_X;
        cfg_data  <= ray_end[COORD_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        phase_total++;
    endtask

    // New vertex: mostly on a coarse grid, sometimes sharing x or y with the last one
    task automatic pick_vertex(output int x, output int y);
        int n;
        n = stored_x.size();
        x = grid_coord();
        y = grid_coord();
        case ($urandom_range(0, 9))
            0: y = stored_y[n-1];
            1: x = stored_x[n-1];
            2: begin
                x = full_coord();
                y = full_coord();
            end
            default: ;
        endcase
    endtask

    // Query point aimed at vertices, edges and vertex heights, plus noise
    task automatic pick_query(output int x, output int y);
        int n, j, k;
        n = stored_x.size();
        j = $urandom_range(0, n - 1);
        k = (j + 1) % n;
        case ($urandom_range(0, 9))
            0, 1: begin
                x = stored_x[j];
                y = stored_y[j];
            end
            2: begin
                x = (stored_x[j] + stored_x[k]) / 2;
                y = (stored_y[j] + stored_y[k]) / 2;
            end
            3, 4: begin
                x = grid_coord();
                y = grid_coord();
            end
            5: begin
                x = grid_coord();
                y = stored_y[j];
            end
            6: begin
                x = stored_x[j] + int'($urandom_range(0, 6)) - 3;
                y = stored_y[j];
            end
            7, 8: begin
                x = full_coord();
                y = full_coord();
            end
            default: begin
                x = extreme_coord();
                y = extreme_coord();
            end
        endcase
    endtask

    initial begin : stimulus
        int phase_eps[NUM_PHASES];
        int phase_ray[NUM_PHASES];
        int add_pct;
        int x, y;

        // Corners of the register ranges first, then random and grid-aligned settings
        phase_eps = '{0, 65535, 1, 0, 0, 1, 2};
        phase_ray = '{32767, -32768, 0, 0, 32767, 0, 0};
        phase_eps[3] = $urandom_range(0, 4095);
        phase_eps[4] = $urandom_range(0, 65535);
        phase_ray[3] = full_coord();
        phase_ray[5] = grid_coord();
        phase_ray[6] = grid_coord();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: growing polygon at the coordinate extremes, reset settings
        send_req(REQ_QUERY, 0, 0);
        idle_gap();
        send_req(REQ_ADD, -32768, -32768);
        send_req(REQ_QUERY, -32768, -32768);
        idle_gap();
        send_req(REQ_ADD, 32767, -32768);
        send_req(REQ_QUERY, 0, -32768);
        send_req(REQ_ADD, 0, 32767);
        idle_gap();
        send_req(REQ_QUERY, 0, 0);
        send_req(REQ_QUERY, -32768, -32768);
        send_req(REQ_QUERY, 0, -32768);
        idle_gap();
        send_req(REQ_QUERY, 32767, 32767);
        send_req(REQ_QUERY, -32768, 32767);
        send_req(REQ_QUERY, 0, 32767);
        send_req(REQ_QUERY, -1, 1);
        idle_gap();
        send_req(REQ_QUERY, 32767, -32768);
        send_req(REQ_ADD, -32768, 32767);
        send_req(REQ_QUERY, -32768, 0);
        send_req(REQ_QUERY, -16384, 16384);

        // Random: fill the store, overflow it, and query under each setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_ray_config(phase_eps[p], phase_ray[p]);
            quiet = (p == NUM_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                idle_gap();
                add_pct = (stored_x.size() < MAX_VERTICES) ? 35 : 4;
                if ($urandom_range(0, 99) < add_pct) begin
                    pick_vertex(x, y);
                    send_req(REQ_ADD, x, y);
                end else begin
                    pick_query(x, y);
                    send_req(REQ_QUERY, x, y);
                end
                if (!quiet && $urandom_range(0, 99) == 0) begin
                    wait_idle();
                end
            end
        end

        // Drain and let the pipeline settle
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d vertex appends (%0d dropped at capacity) and %0d point queries",
                 add_total, full_total, query_total);
        $display("across %0d register settings; %0d queries answered inside or on boundary",
                 phase_total, inside_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[point_in_polygon_ray_cast] OK");
        end else begin
            $display("[point_in_polygon_ray_cast] ERROR");
        end
        $finish;
    end

endmodule
